// ----- rtl/core/alut_pkg.sv -----
// Shared types and constants for the 16-bit ALU with T flag.
// Holds the opcode and error codes and the word structs used across the core.
// No dependencies.
`default_nettype none
package alut_pkg;

	localparam int DATA_W = 16;
	localparam int SH_W   = $clog2(DATA_W);

	typedef enum logic [5:0] {
		OP_NOP  = 6'd0,  OP_MOV  = 6'd1,  OP_ADD  = 6'd2,  OP_ADDC = 6'd3,
		OP_ADDV = 6'd4,  OP_SUB  = 6'd5,  OP_SUBC = 6'd6,  OP_SUBV = 6'd7,
		OP_AND  = 6'd8,  OP_TST  = 6'd9,  OP_NEG  = 6'd10, OP_NEGC = 6'd11,
		OP_NOT  = 6'd12, OP_OR   = 6'd13, OP_XOR  = 6'd14, OP_SEQ  = 6'd15,
		OP_SGE  = 6'd16, OP_SGEU = 6'd17, OP_SGT  = 6'd18, OP_SGTU = 6'd19,
		OP_SGZ  = 6'd20, OP_SGZU = 6'd21, OP_EXTS = 6'd22, OP_EXTU = 6'd23,
		OP_SLL  = 6'd24, OP_SRL  = 6'd25, OP_SRA  = 6'd26, OP_ROT  = 6'd27,
		OP_BCLR = 6'd28, OP_BSET = 6'd29, OP_BNOT = 6'd30, OP_BTST = 6'd31,
		OP_CLRT = 6'd32, OP_SETT = 6'd33, OP_NOTT = 6'd34, OP_MUL  = 6'd35,
		OP_DIVS = 6'd36, OP_MOD  = 6'd37, OP_MULU = 6'd38, OP_DIVU = 6'd39,
		OP_DT   = 6'd40
	} op_e;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_DIV0  = 2'd1,
		ERR_BADOP = 2'd2
	} err_e;

	typedef enum logic [1:0] {
		DK_NONE = 2'd0,
		DK_DIVS = 2'd1,
		DK_MOD  = 2'd2,
		DK_DIVU = 2'd3
	} div_e;

	typedef struct packed {
		logic [5:0]               cmd;
		logic signed [DATA_W-1:0] op_a;
		logic signed [DATA_W-1:0] op_b;
		logic                     t_in;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic                     t_out;
		logic [1:0]               error;
	} out_word_t;

	typedef struct packed {
		logic [5:0]        cmd;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              t;
		div_e              dk;
		logic              bad;
	} dec_t;

	typedef struct packed {
		logic              v;
		logic [DATA_W-1:0] res;
		logic              t;
		err_e              err;
		div_e              dk;
		logic              neg_q;
		logic              neg_r;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] den;
	} stage_t;

endpackage
`default_nettype wire

// ----- rtl/core/alut_front.sv -----
// Front end: classifies an incoming word by operation kind.
// Depends on alut_pkg.
`default_nettype none
module alut_front
	import alut_pkg::*;
(
	input  in_word_t item,
	output dec_t     dec
);

	always_comb begin
		dec.cmd = item.cmd;
		dec.a   = item.op_a;
		dec.b   = item.op_b;
		dec.t   = item.t_in;
		dec.bad = (item.cmd > OP_DT);
		unique case (item.cmd)
			OP_DIVS: dec.dk = DK_DIVS;
			OP_MOD:  dec.dk = DK_MOD;
			OP_DIVU: dec.dk = DK_DIVU;
			default: dec.dk = DK_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/alut_queue.sv -----
// Short queue between front and back ends.
// Depends on alut_pkg.
`default_nettype none
module alut_queue
	import alut_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  dec_t wdata,
	input  logic rd,
	output dec_t rdata,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dec_t            mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/alut_back.sv -----
// Back end: combinational ops and multiply into the first stage, then a bit-per-stage divider
// and an output register. Depends on alut_pkg.
`default_nettype none
module alut_back
	import alut_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dec_t      head,
	input  logic      head_v,
	output logic      take,
	input  logic      pop,
	output logic      empty,
	output out_word_t res
);

	localparam int W = DATA_W;

	stage_t    div_s [W+1];
	stage_t    nxt0;
	stage_t    nxt [W];
	stage_t    fin;
	out_word_t out_q;
	logic      out_v_q;
	logic      en;

	assign en    = !out_v_q || pop;
	assign take  = en && head_v;
	assign empty = !out_v_q;
	assign res   = out_q;

	always_comb begin
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W:0]   wide;
		logic [W-1:0] bitm;
		logic [2*W-1:0] rr;
		logic [SH_W-1:0] sh;
		logic [2*W-1:0] prod;
		a    = head.a;
		b    = head.b;
		sh   = b[SH_W-1:0];
		bitm = W'(1) << sh;
		rr   = {a, a} >> sh;
		prod = a * b;
		wide = '0;
		nxt0       = '0;
		nxt0.v     = take;
		nxt0.t     = head.t;
		nxt0.err   = ERR_NONE;
		nxt0.dk    = head.dk;
		nxt0.res   = '0;
		unique case (head.cmd)
			OP_NOP, OP_MOV: nxt0.res = b;
			OP_ADD:  nxt0.res = a + b;
			OP_ADDC: begin
				wide = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, head.t};
				nxt0.res = wide[W-1:0];
				nxt0.t = wide[W];
			end
			OP_ADDV: begin
				nxt0.res = a + b;
				nxt0.t = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ nxt0.res[W-1]);
			end
			OP_SUB:  nxt0.res = a - b;
			OP_SUBC: begin
				wide = {1'b0, a} - {1'b0, b} - {{W{1'b0}}, head.t};
				nxt0.res = wide[W-1:0];
				nxt0.t = wide[W];
			end
			OP_SUBV: begin
				nxt0.res = a - b;
				nxt0.t = (a[W-1] ^ b[W-1]) & (a[W-1] ^ nxt0.res[W-1]);
			end
			OP_AND:  nxt0.res = a & b;
			OP_TST:  nxt0.t = ((a & b) == '0);
			OP_NEG:  nxt0.res = '0 - b;
			OP_NEGC: begin
				nxt0.res = '0 - b - {{(W-1){1'b0}}, head.t};
				nxt0.t = (b != '0) || head.t;
			end
			OP_NOT:  nxt0.res = ~b;
			OP_OR:   nxt0.res = a | b;
			OP_XOR:  nxt0.res = a ^ b;
			OP_SEQ:  nxt0.t = (a == b);
			OP_SGE:  nxt0.t = ($signed(b) >= $signed(a));
			OP_SGEU: nxt0.t = (b >= a);
			OP_SGT:  nxt0.t = ($signed(b) > $signed(a));
			OP_SGTU: nxt0.t = (b > a);
			OP_SGZ:  nxt0.t = ($signed(a) > $signed(W'(0)));
			OP_SGZU: nxt0.t = (a != '0);
			OP_EXTS: nxt0.res = {{(W-8){b[7]}}, b[7:0]};
			OP_EXTU: nxt0.res = {{(W-8){1'b0}}, b[7:0]};
			OP_SLL:  nxt0.res = a << sh;
			OP_SRL:  nxt0.res = a >> sh;
			OP_SRA:  nxt0.res = W'($signed(a) >>> sh);
			OP_ROT:  nxt0.res = rr[W-1:0];
			OP_BCLR: nxt0.res = a & ~bitm;
			OP_BSET: nxt0.res = a | bitm;
			OP_BNOT: nxt0.res = a ^ bitm;
			OP_BTST: nxt0.t = ((a & bitm) != '0);
			OP_CLRT: nxt0.t = 1'b0;
			OP_SETT: nxt0.t = 1'b1;
			OP_NOTT: nxt0.t = ~head.t;
			OP_MUL, OP_MULU: nxt0.res = prod[W-1:0];
			OP_DIVS, OP_MOD, OP_DIVU: nxt0.res = '0;
			OP_DT: begin
				nxt0.res = a - 1'b1;
				nxt0.t = (nxt0.res == '0);
			end
			default: nxt0.err = ERR_BADOP;
		endcase
		if (head.dk == DK_DIVU) begin
			nxt0.quo = a;
			nxt0.den = b;
		end else begin
			nxt0.quo = a[W-1] ? ('0 - a) : a;
			nxt0.den = b[W-1] ? ('0 - b) : b;
		end
		nxt0.rem   = '0;
		nxt0.neg_q = a[W-1] ^ b[W-1];
		nxt0.neg_r = a[W-1];
	end

	always_comb begin
		logic [W:0] trial;
		for (int k = 0; k < W; k++) begin
			nxt[k] = div_s[k];
			trial  = {div_s[k].rem, div_s[k].quo[W-1]} - {1'b0, div_s[k].den};
			if (!trial[W]) begin
				nxt[k].rem = trial[W-1:0];
				nxt[k].quo = {div_s[k].quo[W-2:0], 1'b1};
			end else begin
				nxt[k].rem = {div_s[k].rem[W-2:0], div_s[k].quo[W-1]};
				nxt[k].quo = {div_s[k].quo[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		fin = div_s[W];
		if (fin.dk != DK_NONE) begin
			if (fin.den == '0) begin
				fin.res = '0;
				fin.err = ERR_DIV0;
			end else begin
				unique case (fin.dk)
					DK_DIVS: fin.res = fin.neg_q ? ('0 - fin.quo) : fin.quo;
					DK_MOD:  fin.res = fin.neg_r ? ('0 - fin.rem) : fin.rem;
					default: fin.res = fin.quo;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= W; k++) begin
				div_s[k] <= '0;
			end
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (en) begin
			div_s[0] <= nxt0;
			for (int k = 0; k < W; k++) begin
				div_s[k+1] <= nxt[k];
			end
			out_v_q      <= fin.v;
			out_q.result <= fin.res;
			out_q.t_out  <= fin.t;
			out_q.error  <= fin.err;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/alu_16bit_with_t_flag_core.sv -----
// Top level of the 16-bit ALU with T flag: front decode, queue, back end.
// Depends on alut_pkg, alut_front, alut_queue, alut_back.
//
// Input channel: write a word on item with push; it is taken at an edge
// where push is high and full is low. Result channel: while empty is low
// res holds the oldest result; pop takes it.
// Path: a pushed word moves from the queue into the first stage, through
// the 16 divider stages, then into the output register; a stall on the
// result side holds every stage.
// Throughput: one word per cycle for every operation while the result side
// does not stall; the divider retires one quotient bit per pipeline stage.
// A stall on the result side freezes the back end; the queue keeps taking
// words until it fills, then full rises.
// Reset clears the queue and all valid bits; no result is pending after.
`default_nettype none
module alu_16bit_with_t_flag_core
	import alut_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  item,
	input  logic      pop,
	output logic      empty,
	output out_word_t res
);

	dec_t dec;
	dec_t head;
	logic q_empty;
	logic take;

	alut_front u_front (
		.item (item),
		.dec  (dec)
	);

	alut_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push && !full),
		.wdata  (dec),
		.rd     (take),
		.rdata  (head),
		.full   (full),
		.empty  (q_empty)
	);

	alut_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.head_v (!q_empty),
		.take   (take),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

endmodule
`default_nettype wire

// ----- rtl/core/alut_checker.sv -----
// Port-level checks for the ALU core, bound to the top level.
// Depends on alut_pkg.
`default_nettype none
module alut_checker
	import alut_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      pop,
	input logic      empty,
	input out_word_t res
);

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(res))
		else $error("result word changed while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (res.error == ERR_NONE || res.error == ERR_DIV0 ||
			res.error == ERR_BADOP))
		else $error("bad error code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.error != ERR_NONE |-> res.result == '0)
		else $error("nonzero result with error");

endmodule

bind alu_16bit_with_t_flag_core alut_checker u_chk (.*);
`default_nettype wire
